@@ rtl/core/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk_i, idle while rst_ni is low.
`define PSU_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("psu assertion failed");

// Implication check on clk_i, idle while rst_ni is low.
`define PSU_ASSERT_IMP(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("psu assertion failed");

`endif

@@ rtl/core/psu_pkg.sv @@
`timescale 1ns / 1ps

package psu_pkg;

  localparam int MaxRowBytes = 4096;
  localparam int IdxW        = $clog2(MaxRowBytes);
  localparam int RowBytesW   = 13;
  localparam int RowCountW   = 16;
  localparam int CfgIdxW     = 2;
  localparam int CfgDataW    = 16;
  localparam int QDepth      = 4;
  localparam int QPtrW       = $clog2(QDepth);
  localparam int QCntW       = $clog2(QDepth + 1);

  localparam logic [2:0] FILT_NONE  = 3'd0;
  localparam logic [2:0] FILT_SUB   = 3'd1;
  localparam logic [2:0] FILT_UP    = 3'd2;
  localparam logic [2:0] FILT_AVG   = 3'd3;
  localparam logic [2:0] FILT_PAETH = 3'd4;

  localparam logic [CfgIdxW-1:0] REG_ROW_BYTES = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] REG_ROW_COUNT = CfgIdxW'(1);

  typedef enum logic {
    ITEM_DATA,
    ITEM_ERR
  } item_kind_e;

  // One request handed from the front end to the reconstruction back end.
  typedef struct packed {
    item_kind_e        kind;
    logic [7:0]        data;
    logic [2:0]        filt;
    logic [IdxW-1:0]   idx;
    logic              first;
    logic              row0;
    logic              rend;
    logic              iend;
  } work_t;

  function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
    logic signed [10:0] pa;
    logic signed [10:0] pb;
    logic signed [10:0] pc;
    logic [7:0]         res;
    // p = a + b - c, so |p-a| = |b-c|, |p-b| = |a-c|, |p-c| = |a+b-2c|
    pa = $signed({3'b000, b}) - $signed({3'b000, c});
    pb = $signed({3'b000, a}) - $signed({3'b000, c});
    pc = pa + pb;
    if (pa < 0) pa = -pa;
    if (pb < 0) pb = -pb;
    if (pc < 0) pc = -pc;
    if (pa <= pb && pa <= pc) begin
      res = a;
    end else if (pb <= pc) begin
      res = b;
    end else begin
      res = c;
    end
    return res;
  endfunction

endpackage

@@ rtl/core/psu_front.sv @@
`timescale 1ns / 1ps

module psu_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [psu_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [psu_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    in_byte_i,
  input  logic                          image_start_i,
  input  logic                          q_full_i,
  output logic                          push_o,
  output psu_pkg::work_t                push_item_o
);
  import psu_pkg::*;

  logic [RowBytesW-1:0] row_bytes_q;
  logic [RowCountW-1:0] row_count_q;
  logic [RowBytesW-1:0] column_q, column_d;
  logic [RowCountW-1:0] row_q, row_d;
  logic [2:0]           filt_q, filt_d;
  logic                 expect_q, expect_d;
  logic                 halted_q, halted_d;

  logic                 accept;
  logic [RowBytesW-1:0] rb_eff;
  logic [RowCountW-1:0] rc_eff;
  logic [RowBytesW-1:0] col_cur, col_next;
  logic [RowCountW-1:0] row_cur;
  logic                 exp_cur, halt_cur;
  logic                 row_last;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_full_i;
  assign accept      = in_valid_i && !q_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_bytes_q <= RowBytesW'(1);
      row_count_q <= RowCountW'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_ROW_BYTES: row_bytes_q <= cfg_data_i[RowBytesW-1:0];
        REG_ROW_COUNT: row_count_q <= cfg_data_i[RowCountW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (row_bytes_q == '0) begin
      rb_eff = RowBytesW'(1);
    end else if (row_bytes_q > RowBytesW'(MaxRowBytes)) begin
      rb_eff = RowBytesW'(MaxRowBytes);
    end else begin
      rb_eff = row_bytes_q;
    end
    rc_eff = (row_count_q == '0) ? RowCountW'(1) : row_count_q;
  end

  // image start overrides the position state before the byte is used
  assign col_cur  = image_start_i ? '0 : column_q;
  assign row_cur  = image_start_i ? '0 : row_q;
  assign exp_cur  = image_start_i ? 1'b1 : expect_q;
  assign halt_cur = image_start_i ? 1'b0 : halted_q;
  assign col_next = col_cur + RowBytesW'(1);
  assign row_last = ({1'b0, row_cur} + (RowCountW+1)'(1)) >= {1'b0, rc_eff};

  always_comb begin
    column_d    = column_q;
    row_d       = row_q;
    filt_d      = filt_q;
    expect_d    = expect_q;
    halted_d    = halted_q;
    push_o      = 1'b0;
    push_item_o = '{kind: ITEM_DATA, data: in_byte_i, filt: filt_q,
                    idx: (col_cur < RowBytesW'(MaxRowBytes)) ? col_cur[IdxW-1:0]
                                                             : IdxW'(MaxRowBytes - 1),
                    first: (col_cur == '0), row0: (row_cur == '0),
                    rend: 1'b0, iend: 1'b0};
    if (accept) begin
      column_d = col_cur;
      row_d    = row_cur;
      expect_d = exp_cur;
      halted_d = halt_cur;
      if (!halt_cur) begin
        if (exp_cur) begin
          if (in_byte_i > 8'(FILT_PAETH)) begin
            push_o           = 1'b1;
            push_item_o.kind = ITEM_ERR;
            push_item_o.data = 8'h00;
            push_item_o.filt = FILT_NONE;
            halted_d         = 1'b1;
          end else begin
            filt_d   = in_byte_i[2:0];
            expect_d = 1'b0;
          end
        end else begin
          push_o   = 1'b1;
          column_d = col_next;
          if (col_next >= rb_eff) begin
            push_item_o.rend = 1'b1;
            column_d         = '0;
            expect_d         = 1'b1;
            if (row_last) begin
              push_item_o.iend = 1'b1;
              halted_d         = 1'b1;
            end else begin
              row_d = row_cur + RowCountW'(1);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q <= '0;
      row_q    <= '0;
      filt_q   <= FILT_NONE;
      expect_q <= 1'b1;
      halted_q <= 1'b0;
    end else begin
      column_q <= column_d;
      row_q    <= row_d;
      filt_q   <= filt_d;
      expect_q <= expect_d;
      halted_q <= halted_d;
    end
  end

endmodule

@@ rtl/core/psu_queue.sv @@
`timescale 1ns / 1ps

module psu_queue (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  psu_pkg::work_t             item_i,
  output logic                       full_o,
  input  logic                       pop_i,
  output logic                       valid_o,
  output psu_pkg::work_t             item_o,
  output logic [psu_pkg::QCntW-1:0]  count_o
);
  import psu_pkg::*;

  work_t            slots_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] count_q, count_d;
  logic             do_pop;

  assign full_o  = (count_q == QCntW'(QDepth));
  assign valid_o = (count_q != '0);
  assign item_o  = slots_q[rd_ptr_q];
  assign count_o = count_q;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    count_d = count_q;
    if (push_i && !do_pop) begin
      count_d = count_q + QCntW'(1);
    end else if (!push_i && do_pop) begin
      count_d = count_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      if (do_pop) rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slots_q[wr_ptr_q] <= item_i;
  end

endmodule

@@ rtl/core/psu_back.sv @@
`timescale 1ns / 1ps

module psu_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  psu_pkg::work_t  q_item_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            row_end_o,
  output logic            image_end_o,
  output logic            bad_filter_o
);
  import psu_pkg::*;

  logic [7:0] line_mem [MaxRowBytes];
  logic [7:0] rdata_q;

  work_t      s1_q;
  logic       s1_valid_q;
  logic       byp_q;
  logic [7:0] byp_data_q;
  logic [7:0] left_q, upleft_q;

  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       row_end_q, image_end_q, bad_q;

  logic       out_ready, s1_adv, s1_ready, mem_we;
  logic [7:0] up, left, upleft, val;
  logic [8:0] sum;

  assign out_ready = !out_valid_q || !out_stall_i;
  assign s1_adv    = s1_valid_q && out_ready;
  assign s1_ready  = !s1_valid_q || s1_adv;
  assign pop_o     = q_valid_i && s1_ready;
  assign mem_we    = s1_adv && (s1_q.kind == ITEM_DATA);

  // A same-cycle write to the entry being fetched would be missed by the
  // registered read, so the written byte is kept aside for that request.
  always_comb begin
    up     = s1_q.row0 ? 8'h00 : (byp_q ? byp_data_q : rdata_q);
    left   = s1_q.first ? 8'h00 : left_q;
    upleft = (s1_q.first || s1_q.row0) ? 8'h00 : upleft_q;
    sum    = {1'b0, left} + {1'b0, up};
    case (s1_q.filt)
      FILT_SUB:   val = s1_q.data + left;
      FILT_UP:    val = s1_q.data + up;
      FILT_AVG:   val = s1_q.data + sum[8:1];
      FILT_PAETH: val = s1_q.data + paeth_pick(left, up, upleft);
      default:    val = s1_q.data;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) line_mem[s1_q.idx] <= val;
    if (pop_o) rdata_q <= line_mem[q_item_i.idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_q       <= q_item_i;
      byp_q      <= mem_we && (s1_q.idx == q_item_i.idx);
      byp_data_q <= val;
    end
    if (mem_we) begin
      left_q   <= val;
      upleft_q <= up;
    end
    if (s1_adv) begin
      out_byte_q  <= val;
      row_end_q   <= s1_q.rend;
      image_end_q <= s1_q.iend;
      bad_q       <= (s1_q.kind == ITEM_ERR);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign row_end_o    = row_end_q;
  assign image_end_o  = image_end_q;
  assign bad_filter_o = bad_q;

endmodule

@@ rtl/core/png_scanline_unfilter.sv @@
`timescale 1ns / 1ps

// PNG scanline unfilter: takes the inflated stream one byte per request
// (a filter type byte, then row_bytes data bytes per row) and returns one
// reconstructed byte per data byte, flagged with row_end and image_end. A
// filter type above 4 returns a single bad_filter request and the rest of
// the image is dropped until image_start. While nothing stalls, the block
// takes one byte and returns one result per cycle; a taken byte passes the
// queue, line store read and reconstruction/output registers. The previous
// row lives in a 4096 x 8 line store with one registered read and one write
// port. Registers are to be written only while the block is idle, which the
// block does not enforce; cfg_ready_o is always high.
module png_scanline_unfilter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [psu_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [psu_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    in_byte_i,
  input  logic                          image_start_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    out_byte_o,
  output logic                          row_end_o,
  output logic                          image_end_o,
  output logic                          bad_filter_o
);
  import psu_pkg::*;

`include "assert_macros.svh"

  logic             q_full, q_push, q_pop, q_valid;
  work_t            q_in, q_out;
  logic [QCntW-1:0] q_count;

  psu_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_byte_i     (in_byte_i),
    .image_start_i (image_start_i),
    .q_full_i      (q_full),
    .push_o        (q_push),
    .push_item_o   (q_in)
  );

  psu_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_out),
    .count_o (q_count)
  );

  psu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_item_i     (q_out),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .row_end_o    (row_end_o),
    .image_end_o  (image_end_o),
    .bad_filter_o (bad_filter_o)
  );

  `PSU_ASSERT(a_q_bound, q_count <= QCntW'(QDepth))
  `PSU_ASSERT_IMP(a_bad_clean, out_valid_o && bad_filter_o,
                  out_byte_o == 8'h00 && !row_end_o && !image_end_o)
  `PSU_ASSERT_IMP(a_iend_rend, out_valid_o && image_end_o, row_end_o)
  `PSU_ASSERT_IMP(a_full_stall, q_full, in_stall_o)

endmodule
